### hdl/lac_pkg.sv
// Package: types, codes and reset constants of the linear actuator controller.
`timescale 1ns / 1ps
`default_nettype none
package lac_pkg;

  localparam int unsigned CFG_W          = 24;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned OP_W           = 3;
  localparam int unsigned MODE_W         = 3;
  localparam int unsigned TIMER_BITS_DEF = 24;

  localparam logic [CFG_W-1:0] TIMEOUT_RST  = CFG_W'(3 * 1000);
  localparam logic [CFG_W-1:0] RUN_TIME_RST = CFG_W'(3 * 1000);

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_EXTEND  = 3'd1,
    OP_RETRACT = 3'd2,
    OP_STOP    = 3'd3,
    OP_RELAX   = 3'd4,
    OP_SYNC    = 3'd5
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_RELAXED    = 3'd0,
    MODE_EXTENDING  = 3'd1,
    MODE_EXTENDED   = 3'd2,
    MODE_RETRACTING = 3'd3,
    MODE_RETRACTED  = 3'd4,
    MODE_TIMEDOUT   = 3'd5,
    MODE_STOPPED    = 3'd6
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT  = 3'd0,
    CFG_RUN_TIME = 3'd1,
    CFG_NORM_OPEN = 3'd2,
    CFG_FEEDBACK = 3'd3,
    CFG_FLIP     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] timeout_ticks;
    logic [CFG_W-1:0] run_time_ticks;
    logic             normally_open;
    logic             has_feedback;
    logic             flip_polarity;
  } cfg_t;

  typedef struct packed {
    mode_e mode;
    mode_e last_mode;
    logic  ext_flag;
    logic  ret_flag;
  } state_t;

  typedef struct packed {
    mode_e mode;
    logic  drive_a;
    logic  drive_b;
    logic  bridge_enable;
    logic  ext_led;
    logic  ret_led;
  } res_t;

endpackage
`default_nettype wire

### hdl/lac_step.sv
// Next-state and result logic for one item of the linear actuator controller.
`timescale 1ns / 1ps
`default_nettype none
module lac_step #(
  parameter int unsigned TIMER_BITS = lac_pkg::TIMER_BITS_DEF
) (
  input  wire  logic [lac_pkg::OP_W-1:0] op_i,
  input  wire  logic                     ext_switch_raw_i,
  input  wire  logic                     ret_switch_raw_i,
  input  wire  lac_pkg::cfg_t            cfg_i,
  input  wire  lac_pkg::state_t          state_i,
  input  wire  logic [TIMER_BITS-1:0]    timer_i,
  output lac_pkg::state_t                state_o,
  output logic [TIMER_BITS-1:0]          timer_o,
  output lac_pkg::res_t                  res_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > lac_pkg::CFG_W) ? TIMER_BITS : lac_pkg::CFG_W;

  logic                  ext_s;
  logic                  ret_s;
  logic                  moving;
  logic                  is_ext;
  logic                  reached;
  logic [TIMER_BITS-1:0] timer_nx;
  logic [CMP_W-1:0]      elapsed_x;
  logic [CMP_W-1:0]      timeout_x;
  logic [CMP_W-1:0]      run_x;

  assign ext_s     = ext_switch_raw_i != cfg_i.normally_open;
  assign ret_s     = ret_switch_raw_i != cfg_i.normally_open;
  assign moving    = (state_i.mode == lac_pkg::MODE_EXTENDING) ||
                     (state_i.mode == lac_pkg::MODE_RETRACTING);
  assign is_ext    = state_i.mode == lac_pkg::MODE_EXTENDING;
  assign timer_nx  = (state_i.mode != state_i.last_mode) ? '0 :
                     (timer_i != '1) ? timer_i + TIMER_BITS'(1) : timer_i;
  assign elapsed_x = CMP_W'(timer_nx);
  assign timeout_x = CMP_W'(cfg_i.timeout_ticks);
  assign run_x     = CMP_W'(cfg_i.run_time_ticks);
  assign reached   = cfg_i.has_feedback &&
                     (is_ext ? (ext_s && !ret_s) : (ret_s && !ext_s));

  always_comb begin
    state_o = state_i;
    timer_o = timer_i;
    unique case (lac_pkg::op_e'(op_i))
      lac_pkg::OP_TICK: begin
        state_o.ext_flag  = ext_s;
        state_o.ret_flag  = ret_s;
        state_o.last_mode = state_i.mode;
        if (moving) begin
          timer_o = timer_nx;
          if (cfg_i.has_feedback && (timeout_x != '0) && (elapsed_x >= timeout_x)) begin
            state_o.mode = lac_pkg::MODE_TIMEDOUT;
          end
          if (reached || (!cfg_i.has_feedback && (elapsed_x >= run_x))) begin
            state_o.mode = is_ext ? lac_pkg::MODE_EXTENDED : lac_pkg::MODE_RETRACTED;
          end
        end
      end
      lac_pkg::OP_EXTEND: begin
        if (!state_i.ext_flag) state_o.mode = lac_pkg::MODE_EXTENDING;
      end
      lac_pkg::OP_RETRACT: begin
        if (!state_i.ret_flag) state_o.mode = lac_pkg::MODE_RETRACTING;
      end
      lac_pkg::OP_STOP:  state_o.mode = lac_pkg::MODE_STOPPED;
      lac_pkg::OP_RELAX: state_o.mode = lac_pkg::MODE_RELAXED;
      lac_pkg::OP_SYNC: begin
        state_o.ext_flag = ext_s;
        state_o.ret_flag = ret_s;
        if (ext_s) begin
          state_o.mode = lac_pkg::MODE_EXTENDED;
        end else if (ret_s) begin
          state_o.mode = lac_pkg::MODE_RETRACTED;
        end else begin
          state_o.mode = lac_pkg::MODE_RELAXED;
        end
        state_o.last_mode = state_o.mode;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.mode          = state_o.mode;
    res_o.drive_a       = 1'b0;
    res_o.drive_b       = 1'b0;
    res_o.bridge_enable = state_o.mode != lac_pkg::MODE_RELAXED;
    res_o.ext_led       = state_o.ext_flag;
    res_o.ret_led       = state_o.ret_flag;
    if (state_o.mode == lac_pkg::MODE_EXTENDING) begin
      res_o.drive_a = !cfg_i.flip_polarity;
      res_o.drive_b = cfg_i.flip_polarity;
    end else if (state_o.mode == lac_pkg::MODE_RETRACTING) begin
      res_o.drive_a = cfg_i.flip_polarity;
      res_o.drive_b = !cfg_i.flip_polarity;
    end
  end

endmodule
`default_nettype wire

### hdl/linear_actuator_controller.sv
// Top level: linear actuator controller with config registers and result register.
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while out_ready_i is high; the result register drains while the next item enters.
// The state update and result are one combinational pass from state to result register.
// Reset: mode relaxed, timer and switch flags cleared, result register empty,
// config registers at timeout 3000, run time 3000, normally open, feedback on, no flip.
`timescale 1ns / 1ps
`default_nettype none
module linear_actuator_controller #(
  parameter int unsigned TIMER_BITS = lac_pkg::TIMER_BITS_DEF
) (
  input  wire  logic                          clk_i,
  input  wire  logic                          rst_ni,
  input  wire  logic                          in_valid_i,
  output logic                                in_ready_o,
  input  wire  logic [lac_pkg::OP_W-1:0]      op_i,
  input  wire  logic                          ext_switch_raw_i,
  input  wire  logic                          ret_switch_raw_i,
  output logic                                out_valid_o,
  input  wire  logic                          out_ready_i,
  output logic [lac_pkg::MODE_W-1:0]          mode_o,
  output logic                                drive_a_o,
  output logic                                drive_b_o,
  output logic                                bridge_enable_o,
  output logic                                ext_led_o,
  output logic                                ret_led_o,
  input  wire  logic                          cfg_we_i,
  input  wire  logic [lac_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  logic [lac_pkg::CFG_W-1:0]     cfg_data_i
);

  lac_pkg::cfg_t         cfg_q;
  lac_pkg::state_t       state_q;
  lac_pkg::state_t       state_d;
  logic [TIMER_BITS-1:0] timer_q;
  logic [TIMER_BITS-1:0] timer_d;
  lac_pkg::res_t         res_q;
  lac_pkg::res_t         res_d;
  logic                  out_valid_q;
  logic                  accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  lac_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .op_i            (op_i),
    .ext_switch_raw_i(ext_switch_raw_i),
    .ret_switch_raw_i(ret_switch_raw_i),
    .cfg_i           (cfg_q),
    .state_i         (state_q),
    .timer_i         (timer_q),
    .state_o         (state_d),
    .timer_o         (timer_d),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks  <= lac_pkg::TIMEOUT_RST;
      cfg_q.run_time_ticks <= lac_pkg::RUN_TIME_RST;
      cfg_q.normally_open  <= 1'b1;
      cfg_q.has_feedback   <= 1'b1;
      cfg_q.flip_polarity  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (lac_pkg::cfg_idx_e'(cfg_idx_i))
        lac_pkg::CFG_TIMEOUT:   cfg_q.timeout_ticks  <= cfg_data_i;
        lac_pkg::CFG_RUN_TIME:  cfg_q.run_time_ticks <= cfg_data_i;
        lac_pkg::CFG_NORM_OPEN: cfg_q.normally_open  <= cfg_data_i[0];
        lac_pkg::CFG_FEEDBACK:  cfg_q.has_feedback   <= cfg_data_i[0];
        lac_pkg::CFG_FLIP:      cfg_q.flip_polarity  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= lac_pkg::MODE_RELAXED;
      state_q.last_mode <= lac_pkg::MODE_RELAXED;
      state_q.ext_flag  <= 1'b0;
      state_q.ret_flag  <= 1'b0;
      timer_q           <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        timer_q     <= timer_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = res_q.mode;
  assign drive_a_o       = res_q.drive_a;
  assign drive_b_o       = res_q.drive_b;
  assign bridge_enable_o = res_q.bridge_enable;
  assign ext_led_o       = res_q.ext_led;
  assign ret_led_o       = res_q.ret_led;

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

  a_enable_vs_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bridge_enable_o == (mode_o != lac_pkg::MODE_RELAXED)))
    else $error("bridge enable disagrees with mode");

  a_drive_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((mode_o == lac_pkg::MODE_EXTENDING) ||
                    (mode_o == lac_pkg::MODE_RETRACTING)) |-> (drive_a_o != drive_b_o))
    else $error("drive lines not complementary while moving");

  a_drive_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o != lac_pkg::MODE_EXTENDING) &&
    (mode_o != lac_pkg::MODE_RETRACTING) |-> (!drive_a_o && !drive_b_o))
    else $error("drive active outside a move");

  a_timer_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == lac_pkg::OP_TICK) && (state_q.mode != state_q.last_mode) &&
    ((state_q.mode == lac_pkg::MODE_EXTENDING) ||
     (state_q.mode == lac_pkg::MODE_RETRACTING)) |=> (timer_q == '0))
    else $error("move timer not restarted on new move");
`endif

endmodule
`default_nettype wire

### tb/sv/linear_actuator_controller_test.sv
// Testbench: linear actuator controller driven item by item and checked against a mode predictor.
`timescale 1ns / 1ps
module linear_actuator_controller_test;
  import lac_pkg::*;

  localparam int unsigned TIMER_W    = TIMER_BITS_DEF;
  localparam int unsigned N_DIR      = 25;
  localparam int unsigned N_FIXED    = 7;
  localparam int unsigned N_PHASES   = 9;
  localparam int unsigned PHASE_ITEMS = 92;
  localparam int unsigned LONG_HOLD  = 200;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam res_t RES_NONE  = '0;
  localparam res_t RES_IDLE  = '{MODE_RELAXED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam res_t RES_EXT_GO = '{MODE_EXTENDING, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ext_raw;
    logic            ret_raw;
    logic            fixed;
    res_t            want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{OP_TICK,    1'b1, 1'b1, 1'b1, RES_IDLE},
    '{OP_SPARE_6, 1'b0, 1'b0, 1'b1, RES_IDLE},
    '{OP_SPARE_7, 1'b0, 1'b0, 1'b1, RES_IDLE},
    '{OP_EXTEND,  1'b0, 1'b0, 1'b1, RES_EXT_GO},
    '{OP_TICK,    1'b1, 1'b1, 1'b0, RES_NONE},
    '{OP_TICK,    1'b1, 1'b1, 1'b0, RES_NONE},
    '{OP_TICK,    1'b0, 1'b1, 1'b0, RES_NONE},
    '{OP_EXTEND,  1'b1, 1'b1, 1'b0, RES_NONE},
    '{OP_RETRACT, 1'b1, 1'b1, 1'b0, RES_NONE},
    '{OP_TICK,    1'b1, 1'b0, 1'b0, RES_NONE},
    '{OP_RETRACT, 1'b1, 1'b1, 1'b0, RES_NONE},
    '{OP_STOP,    1'b0, 1'b0, 1'b0, RES_NONE},
    '{OP_RELAX,   1'b0, 1'b0, 1'b0, RES_NONE},
    '{OP_TICK,    1'b0, 1'b0, 1'b0, RES_NONE},
    '{OP_EXTEND,  1'b1, 1'b1, 1'b0, RES_NONE},
    '{OP_SYNC,    1'b0, 1'b0, 1'b0, RES_NONE},
    '{OP_SYNC,    1'b1, 1'b0, 1'b0, RES_NONE},
    '{OP_SYNC,    1'b1, 1'b1, 1'b1, RES_IDLE},
    '{OP_RETRACT, 1'b0, 1'b0, 1'b0, RES_NONE},
    '{OP_TICK,    1'b0, 1'b0, 1'b0, RES_NONE},
    '{OP_TICK,    1'b0, 1'b0, 1'b0, RES_NONE},
    '{OP_STOP,    1'b1, 1'b1, 1'b0, RES_NONE},
    '{OP_RETRACT, 1'b1, 1'b1, 1'b0, RES_NONE},
    '{OP_TICK,    1'b1, 1'b1, 1'b0, RES_NONE},
    '{OP_SYNC,    1'b1, 1'b1, 1'b0, RES_NONE}
  };

  localparam cfg_t PHASE_CFG [N_FIXED] = '{
    '{24'd6,      24'd5,      1'b1, 1'b1, 1'b1},
    '{24'd0,      24'd3,      1'b0, 1'b1, 1'b0},
    '{24'd4,      24'd0,      1'b1, 1'b0, 1'b1},
    '{24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, 1'b0},
    '{24'd3,      24'd7,      1'b1, 1'b0, 1'b0},
    '{24'd1,      24'd2,      1'b0, 1'b1, 1'b1},
    '{24'hFFFFFF, 24'd1,      1'b1, 1'b1, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      op;
  logic                 ext_raw;
  logic                 ret_raw;
  logic                 out_valid;
  logic                 out_ready;
  logic [MODE_W-1:0]    mode;
  logic                 drive_a;
  logic                 drive_b;
  logic                 bridge_en;
  logic                 ext_led;
  logic                 ret_led;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  logic                 item_fixed;
  res_t                 item_want;
  logic                 idle_on;
  logic                 long_hold_req;
  int unsigned          mismatch_cnt;
  res_t                 pending_res [$];

  logic [CFG_W-1:0]     cfg_timeout;
  logic [CFG_W-1:0]     cfg_run;
  logic                 cfg_no;
  logic                 cfg_fb;
  logic                 cfg_flip;
  mode_e                act_mode;
  mode_e                seen_mode;
  logic [TIMER_W-1:0]   elapsed;
  logic                 ext_flag;
  logic                 ret_flag;

  linear_actuator_controller u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .op_i             (op),
    .ext_switch_raw_i (ext_raw),
    .ret_switch_raw_i (ret_raw),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .mode_o           (mode),
    .drive_a_o        (drive_a),
    .drive_b_o        (drive_b),
    .bridge_enable_o  (bridge_en),
    .ext_led_o        (ext_led),
    .ret_led_o        (ret_led),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic res_t step_actuator(logic [OP_W-1:0] cmd, logic e_raw, logic r_raw);
    res_t res;
    logic hit;
    hit = 1'b0;
    case (cmd)
      OP_TICK: begin
        ext_flag = (e_raw != cfg_no);
        ret_flag = (r_raw != cfg_no);
        if (act_mode == MODE_EXTENDING || act_mode == MODE_RETRACTING) begin
          if (act_mode != seen_mode) begin
            elapsed   = '0;
            seen_mode = act_mode;
          end else if (elapsed != '1) begin
            elapsed = elapsed + 1'b1;
          end
          if (cfg_fb && cfg_timeout != '0 && elapsed >= cfg_timeout) act_mode = MODE_TIMEDOUT;
          if (seen_mode == MODE_EXTENDING) hit = cfg_fb && ext_flag && !ret_flag;
          else hit = cfg_fb && ret_flag && !ext_flag;
          if (hit || (!cfg_fb && elapsed >= cfg_run))
            act_mode = (seen_mode == MODE_EXTENDING) ? MODE_EXTENDED : MODE_RETRACTED;
        end else begin
          seen_mode = act_mode;
        end
      end
      OP_EXTEND:  if (!ext_flag) act_mode = MODE_EXTENDING;
      OP_RETRACT: if (!ret_flag) act_mode = MODE_RETRACTING;
      OP_STOP:    act_mode = MODE_STOPPED;
      OP_RELAX:   act_mode = MODE_RELAXED;
      OP_SYNC: begin
        ext_flag = (e_raw != cfg_no);
        ret_flag = (r_raw != cfg_no);
        if (ext_flag) act_mode = MODE_EXTENDED;
        else if (ret_flag) act_mode = MODE_RETRACTED;
        else act_mode = MODE_RELAXED;
        seen_mode = act_mode;
      end
      default: ;
    endcase
    res.mode          = act_mode;
    res.drive_a       = (act_mode == MODE_EXTENDING) ? !cfg_flip :
                        (act_mode == MODE_RETRACTING) ? cfg_flip : 1'b0;
    res.drive_b       = (act_mode == MODE_EXTENDING) ? cfg_flip :
                        (act_mode == MODE_RETRACTING) ? !cfg_flip : 1'b0;
    res.bridge_enable = (act_mode != MODE_RELAXED);
    res.ext_led       = ext_flag;
    res.ret_led       = ret_flag;
    return res;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{mode_e'(mode), drive_a, drive_b, bridge_en, ext_led, ret_led};
        if (pending_res.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: mode=%0d a=%b b=%b en=%b leds=%b%b",
                     mode, drive_a, drive_b, bridge_en, ext_led, ret_led);
        end else begin
          want = pending_res.pop_front();
          if (got.mode != want.mode || got.drive_a != want.drive_a ||
              got.drive_b != want.drive_b || got.bridge_enable != want.bridge_enable ||
              got.ext_led != want.ext_led || got.ret_led != want.ret_led) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch: want mode=%0d a=%b b=%b en=%b leds=%b%b",
                       want.mode, want.drive_a, want.drive_b, want.bridge_enable,
                       want.ext_led, want.ret_led);
              $display("          got  mode=%0d a=%b b=%b en=%b leds=%b%b",
                       got.mode, got.drive_a, got.drive_b, got.bridge_enable,
                       got.ext_led, got.ret_led);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        want = step_actuator(op, ext_raw, ret_raw);
        pending_res.push_back(item_fixed ? item_want : want);
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TIMEOUT:   cfg_timeout = cfg_data;
          CFG_RUN_TIME:  cfg_run     = cfg_data;
          CFG_NORM_OPEN: cfg_no      = cfg_data[0];
          CFG_FEEDBACK:  cfg_fb      = cfg_data[0];
          CFG_FLIP:      cfg_flip    = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_item(logic [OP_W-1:0] cmd, logic e_raw, logic r_raw, logic fixed,
                           res_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid   = 1'b1;
    op         = cmd;
    ext_raw    = e_raw;
    ret_raw    = r_raw;
    item_fixed = fixed;
    item_want  = want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(cfg_t c);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [CFG_W-1:0]     val [5];
    idx = '{CFG_TIMEOUT, CFG_RUN_TIME, CFG_NORM_OPEN, CFG_FEEDBACK, CFG_FLIP};
    val = '{c.timeout_ticks, c.run_time_ticks,
            {23'($urandom), c.normally_open},
            {23'($urandom), c.has_feedback},
            {23'($urandom), c.flip_polarity}};
    for (int i = 0; i < 5; i++) begin
      cfg_we   = 1'b1;
      cfg_idx  = idx[i];
      cfg_data = val[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  function automatic logic [1:0] pick_switches();
    logic ea;
    logic ra;
    if ($urandom_range(0, 3) == 0) return 2'($urandom);
    ea = ($urandom_range(0, 7) == 0);
    ra = ($urandom_range(0, 7) == 0);
    return {ea ^ cfg_no, ra ^ cfg_no};
  endfunction

  initial begin
    cfg_t            c;
    logic [1:0]      sw;
    logic [OP_W-1:0] cmd;
    int unsigned     pick;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    op            = OP_TICK;
    ext_raw       = 1'b0;
    ret_raw       = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_TIMEOUT;
    cfg_data      = '0;
    item_fixed    = 1'b0;
    item_want     = RES_NONE;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    mismatch_cnt  = 0;
    cfg_timeout   = TIMEOUT_RST;
    cfg_run       = RUN_TIME_RST;
    cfg_no        = 1'b1;
    cfg_fb        = 1'b1;
    cfg_flip      = 1'b0;
    act_mode      = MODE_RELAXED;
    seen_mode     = MODE_RELAXED;
    elapsed       = '0;
    ext_flag      = 1'b0;
    ret_flag      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_item(DIR_ROWS[i].op, DIR_ROWS[i].ext_raw, DIR_ROWS[i].ret_raw,
                DIR_ROWS[i].fixed, DIR_ROWS[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      if (p < N_FIXED) begin
        c = PHASE_CFG[p];
      end else begin
        c.timeout_ticks  = CFG_W'($urandom_range(0, 12));
        c.run_time_ticks = CFG_W'($urandom_range(0, 12));
        c.normally_open  = 1'($urandom);
        c.has_feedback   = 1'($urandom);
        c.flip_polarity  = 1'($urandom);
      end
      write_cfg(c);
      idle_on = (p != N_PHASES - 1);
      if (p == 1) long_hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) cmd = OP_TICK;
        else if (pick < 67) cmd = OP_EXTEND;
        else if (pick < 79) cmd = OP_RETRACT;
        else if (pick < 84) cmd = OP_STOP;
        else if (pick < 89) cmd = OP_RELAX;
        else if (pick < 96) cmd = OP_SYNC;
        else if (pick < 98) cmd = OP_SPARE_6;
        else cmd = OP_SPARE_7;
        sw = pick_switches();
        send_item(cmd, sw[1], sw[0], 1'b0, RES_NONE);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_res.size() == 0) begin
      $display("linear_actuator_controller_test: PASS");
    end else begin
      $display("linear_actuator_controller_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("linear_actuator_controller_test: FAIL");
    $finish;
  end

endmodule
